// ===== design/sync_frame_deframer_xor_check_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sync-byte frame deframer
// Short forms for concurrent checks on the block's ports.
// ---------------------------------------------------------------------------
`ifndef SYNC_FRAME_DEFRAMER_XOR_CHECK_MACROS_SVH
`define SYNC_FRAME_DEFRAMER_XOR_CHECK_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define SFD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, off while reset is high.
`define SFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define SFD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("post-reset check failed");

`endif

// ===== design/sfd_pkg.sv =====
// ---------------------------------------------------------------------------
// Sync-byte frame deframer package
// Shared constants, result type and status decode.
// ---------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

   localparam int unsigned ByteW     = 8;
   localparam int unsigned DirW      = 2;
   localparam int unsigned PayloadN  = 6;
   localparam int unsigned PosW      = 3;

   localparam logic [ByteW-1:0] SyncReset = 8'h55;

   // frame position codes
   localparam logic [PosW-1:0] PosHunt  = 3'd0;
   localparam logic [PosW-1:0] PosFirst = 3'd1;
   localparam logic [PosW-1:0] PosLast  = 3'd6;
   localparam logic [PosW-1:0] PosCheck = 3'd7;

   // raw status codes on the wire
   localparam logic [ByteW-1:0] RawReverse = 8'd0;
   localparam logic [ByteW-1:0] RawForward = 8'd1;
   localparam logic [ByteW-1:0] RawStopped = 8'd2;

   // decoded direction codes
   localparam logic [DirW-1:0] DirForward = 2'd0;
   localparam logic [DirW-1:0] DirReverse = 2'd1;
   localparam logic [DirW-1:0] DirStopped = 2'd2;
   localparam logic [DirW-1:0] DirUnknown = 2'd3;

   typedef struct packed {
      logic [ByteW-1:0] received_check;
      logic [ByteW-1:0] computed_check;
      logic [DirW-1:0]  right_direction;
      logic [ByteW-1:0] right_speed;
      logic [ByteW-1:0] right_pwm;
      logic [DirW-1:0]  left_direction;
      logic [ByteW-1:0] left_speed;
      logic [ByteW-1:0] left_pwm;
      logic             frame_ok;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type data;
   } core_out_type;

   function automatic logic [DirW-1:0] decode_status(input logic [ByteW-1:0] raw);
      logic [DirW-1:0] dir;
      case (raw)
         RawForward: dir = DirForward;
         RawReverse: dir = DirReverse;
         RawStopped: dir = DirStopped;
         default:    dir = DirUnknown;
      endcase
      return dir;
   endfunction

endpackage

`default_nettype wire

// ===== design/sfd_in_reg.sv =====
// ---------------------------------------------------------------------------
// Input register
// Holds one received byte until the frame core takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module sfd_in_reg (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic [sfd_pkg::ByteW-1:0]  in_byte,
   input  wire logic                       take,
   output logic                            held_valid,
   output logic [sfd_pkg::ByteW-1:0]       held_byte
);

   logic                      valid_ff, valid_in;
   logic [sfd_pkg::ByteW-1:0] byte_ff, byte_in;
   logic                      load;

   assign in_ready   = !valid_ff || take;
   assign load       = in_valid && in_ready;
   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = in_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

endmodule

`default_nettype wire

// ===== design/sfd_core.sv =====
// ---------------------------------------------------------------------------
// Frame core
// Tracks frame position, folds the XOR check and builds the result.
// ---------------------------------------------------------------------------
`default_nettype none

module sfd_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       held_valid,
   input  wire logic [sfd_pkg::ByteW-1:0]  held_byte,
   input  wire logic [sfd_pkg::ByteW-1:0]  sync_byte,
   input  wire logic                       out_free,
   output logic                            take,
   output sfd_pkg::core_out_type           core_out
);

   logic [sfd_pkg::PosW-1:0]  pos_ff, pos_in;
   logic [sfd_pkg::ByteW-1:0] xor_ff, xor_in;
   logic [sfd_pkg::ByteW-1:0] payload_ff [sfd_pkg::PayloadN];
   logic                      is_check;
   logic                      is_payload;
   logic [sfd_pkg::PosW-1:0]  slot;

   assign is_check   = (pos_ff == sfd_pkg::PosCheck);
   assign is_payload = (pos_ff >= sfd_pkg::PosFirst) && (pos_ff <= sfd_pkg::PosLast);
   assign slot       = pos_ff - sfd_pkg::PosFirst;

   // stall only a check byte whose result has nowhere to go
   assign take = held_valid && (!is_check || out_free);

   always_comb begin
      pos_in = pos_ff;
      xor_in = xor_ff;
      if (take) begin
         if (pos_ff == sfd_pkg::PosHunt) begin
            if (held_byte == sync_byte) begin
               pos_in = sfd_pkg::PosFirst;
               xor_in = held_byte;
            end
         end else if (is_payload) begin
            pos_in = pos_ff + sfd_pkg::PosFirst;
            xor_in = xor_ff ^ held_byte;
         end else begin
            pos_in = sfd_pkg::PosHunt;
            xor_in = '0;
         end
      end
   end

   always_comb begin
      core_out.valid                = take && is_check;
      core_out.data.left_pwm        = payload_ff[0];
      core_out.data.left_speed      = payload_ff[1];
      core_out.data.left_direction  = sfd_pkg::decode_status(payload_ff[2]);
      core_out.data.right_pwm       = payload_ff[3];
      core_out.data.right_speed     = payload_ff[4];
      core_out.data.right_direction = sfd_pkg::decode_status(payload_ff[5]);
      core_out.data.computed_check  = xor_ff;
      core_out.data.received_check  = held_byte;
      core_out.data.frame_ok        = (xor_ff == held_byte);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= sfd_pkg::PosHunt;
         xor_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         xor_ff <= xor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && is_payload) begin
         payload_ff[slot] <= held_byte;
      end
   end

endmodule

`default_nettype wire

// ===== design/sfd_out_reg.sv =====
// ---------------------------------------------------------------------------
// Output register
// Holds one finished result until the sink takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module sfd_out_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sfd_pkg::core_out_type core_out,
   output logic                       out_free,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output sfd_pkg::result_type        out_data
);

   logic                valid_ff, valid_in;
   sfd_pkg::result_type data_ff, data_in;

   assign out_free  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (core_out.valid) begin
         valid_in = 1'b1;
         data_in  = core_out.data;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

// ===== design/sync_frame_deframer_xor_check.sv =====
// Path: a check byte waits in the input register until the core takes it, and its result is
// then held in the output register, shown on rsp_*, until the result transfer completes.
// Throughput: one byte per cycle; the output register lets the next bytes in while a
// result waits, and only a check byte stalls when the previous result is still held.
// Reset: synchronous; hunts for sync, clears the running XOR, sync_byte returns to 0x55;
// payload bytes are not cleared (each is written in a frame before it is read).
// ---------------------------------------------------------------------------
// Sync-byte frame deframer with XOR check
// Hunts for the sync byte, collects six payload bytes and a check byte,
// and emits one decoded result per frame with a check pass flag.
// ---------------------------------------------------------------------------
`default_nettype none

module sync_frame_deframer_xor_check (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte stream in
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   // frame results out
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // [7:0] left_pwm, [15:8] left_speed,
                                         // [17:16] left_direction, [25:18] right_pwm,
                                         // [33:26] right_speed, [35:34] right_direction,
                                         // [43:36] computed_check, [51:44] received_check,
                                         // [55:52] zero
   output logic             rsp_tuser,   // [0] frame_ok
   // sync byte register write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data     // [7:0] sync_byte
);

   logic                      held_valid;
   logic [sfd_pkg::ByteW-1:0] held_byte;
   logic                      take;
   logic                      out_free;
   sfd_pkg::core_out_type     core_out;
   sfd_pkg::result_type       rsp_data;
   logic [sfd_pkg::ByteW-1:0] sync_ff, sync_in;

   // Sync register: always ready; a write is registered and applies
   // from the next hunt, since the frame in flight already folded its sync.
   assign csr_ready = 1'b1;

   always_comb begin
      sync_in = sync_ff;
      if (csr_valid) begin
         sync_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= sfd_pkg::SyncReset;
      end else begin
         sync_ff <= sync_in;
      end
   end

   // Input stage: hold one byte; advance whenever the core takes it.
   sfd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .take       (take),
      .held_valid (held_valid),
      .held_byte  (held_byte)
   );

   // Frame core: position counter, running XOR, payload slots, status decode.
   sfd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .held_valid (held_valid),
      .held_byte  (held_byte),
      .sync_byte  (sync_ff),
      .out_free   (out_free),
      .take       (take),
      .core_out   (core_out)
   );

   // Output stage: hold a finished result until its transfer completes.
   sfd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .core_out  (core_out),
      .out_free  (out_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   // Pack the result fields, lowest field first, zero padded to whole bytes.
   assign rsp_tdata = {4'b0000,
                       rsp_data.received_check,
                       rsp_data.computed_check,
                       rsp_data.right_direction,
                       rsp_data.right_speed,
                       rsp_data.right_pwm,
                       rsp_data.left_direction,
                       rsp_data.left_speed,
                       rsp_data.left_pwm};
   assign rsp_tuser = rsp_data.frame_ok;

endmodule

`default_nettype wire

// ===== design/sync_frame_deframer_xor_check_checker.sv =====
// ---------------------------------------------------------------------------
// Port checker for the sync-byte frame deframer
// Watches the top level's ports and flags behavior that cannot occur.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sync_frame_deframer_xor_check_macros.svh"

module sync_frame_deframer_xor_check_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   // a stalled result stays offered
   `SFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // the pass flag agrees with the two check bytes it reports
   `SFD_ASSERT_SAME(a_ok_match, clock, reset, rsp_tvalid, rsp_tuser == (rsp_tdata[43:36] == rsp_tdata[51:44]))

   // reset drops any pending result
   `SFD_ASSERT_NEXT_ALWAYS(a_rsp_reset, clock, reset, !rsp_tvalid)

   // reset empties the input stage, so a byte can be taken at once
   `SFD_ASSERT_NEXT_ALWAYS(a_req_reset, clock, reset, req_tready)

endmodule

bind sync_frame_deframer_xor_check sync_frame_deframer_xor_check_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// Testbench for the sync-byte frame deframer
// Streams bytes into the deframer, predicts every frame result from a
// private model of the hunt and collect logic, and checks each result
// field by field. It walks through several sync settings, including a
// sync change in the middle of a frame.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;

   localparam int unsigned CycleLimit  = 200000;
   localparam int unsigned ByteTarget  = 1550;
   localparam int unsigned PhaseCount  = 6;
   localparam int unsigned MaxReports  = 10;
   localparam int unsigned SettleTicks = 6;
   localparam int unsigned HoldAtByte  = 300;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_data;

   int unsigned cycle_count  = 0;
   int unsigned results_seen = 0;
   int unsigned bytes_sent   = 0;

   // ------------------------------------------------------------------------
   // Frame predictor and result store
   // Mirrors the hunt/collect state; every accepted byte is folded in, and
   // each check byte pushes one expected frame result.
   // ------------------------------------------------------------------------
   class frame_board;
      logic [sfd_pkg::ByteW-1:0] sync_value;
      logic [sfd_pkg::PosW-1:0]  position;
      logic [sfd_pkg::ByteW-1:0] run_xor;
      logic [sfd_pkg::ByteW-1:0] payload [sfd_pkg::PayloadN];
      sfd_pkg::result_type       frames_due [$];
      int unsigned               mismatches;

      function new();
         sync_value = sfd_pkg::SyncReset;
         position   = sfd_pkg::PosHunt;
         run_xor    = '0;
         mismatches = 0;
      endfunction

      function void set_sync(logic [sfd_pkg::ByteW-1:0] v);
         sync_value = v;
      endfunction

      function logic [sfd_pkg::DirW-1:0] direction_of(logic [sfd_pkg::ByteW-1:0] raw);
         logic [sfd_pkg::DirW-1:0] d;
         if (raw == sfd_pkg::RawForward)      d = sfd_pkg::DirForward;
         else if (raw == sfd_pkg::RawReverse) d = sfd_pkg::DirReverse;
         else if (raw == sfd_pkg::RawStopped) d = sfd_pkg::DirStopped;
         else                                 d = sfd_pkg::DirUnknown;
         return d;
      endfunction

      function void note_byte(logic [sfd_pkg::ByteW-1:0] b);
         sfd_pkg::result_type r;
         if (position == sfd_pkg::PosHunt) begin
            // drop everything but the sync byte while hunting
            if (b == sync_value) begin
               run_xor  = b;
               position = sfd_pkg::PosFirst;
            end
         end else if (position != sfd_pkg::PosCheck) begin
            // sync value inside a frame is plain payload
            payload[position - sfd_pkg::PosFirst] = b;
            run_xor  = run_xor ^ b;
            position = position + 1'b1;
         end else begin
            r.left_pwm        = payload[0];
            r.left_speed      = payload[1];
            r.left_direction  = direction_of(payload[2]);
            r.right_pwm       = payload[3];
            r.right_speed     = payload[4];
            r.right_direction = direction_of(payload[5]);
            r.frame_ok        = (run_xor == b);
            r.computed_check  = run_xor;
            r.received_check  = b;
            frames_due.push_back(r);
            position = sfd_pkg::PosHunt;
            run_xor  = '0;
         end
      endfunction

      function void field_check(string name, logic [7:0] want_v, logic [7:0] got_v);
         if (want_v !== got_v) begin
            mismatches++;
            if (mismatches <= MaxReports)
               $display("mismatch on %s: expected %h, got %h", name, want_v, got_v);
         end
      endfunction

      function void check_result(logic [55:0] data, logic ok_bit);
         sfd_pkg::result_type want;
         if (frames_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReports)
               $display("frame result with nothing expected: data %h ok %b", data, ok_bit);
            return;
         end
         want = frames_due.pop_front();
         field_check("left_pwm",        want.left_pwm,            data[7:0]);
         field_check("left_speed",      want.left_speed,          data[15:8]);
         field_check("left_direction",  8'(want.left_direction),  8'(data[17:16]));
         field_check("right_pwm",       want.right_pwm,           data[25:18]);
         field_check("right_speed",     want.right_speed,         data[33:26]);
         field_check("right_direction", 8'(want.right_direction), 8'(data[35:34]));
         field_check("computed_check",  want.computed_check,      data[43:36]);
         field_check("received_check",  want.received_check,      data[51:44]);
         field_check("frame_ok",        8'(want.frame_ok),        8'(ok_bit));
      endfunction

      function int unsigned pending();
         return frames_due.size();
      endfunction
   endclass

   frame_board board;

   sync_frame_deframer_xor_check dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Check every result transfer against the oldest predicted frame.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_result(rsp_tdata, rsp_tuser);
         results_seen <= results_seen + 1;
      end
   end

   // Both sides run without idling inside this cycle window.
   function automatic bit steady_window();
      return cycle_count >= 1500 && cycle_count < 2300;
   endfunction

   // Result side: random back-pressure, plus one long hold-off in the middle
   // of a traffic phase that lets the deframer fill up and stall its input.
   initial begin : result_sink
      int unsigned hold_left;
      bit          held_once;
      hold_left  = 0;
      held_once  = 1'b0;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (!held_once && bytes_sent >= HoldAtByte) begin
            held_once = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (steady_window()) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 34);
         end
         @(negedge clock);
      end
   end

   // Offer one byte and hold it until the transfer; idle first at random.
   // Leaves req_tvalid high so a back-to-back byte needs no second update.
   task automatic send_byte(input logic [7:0] b);
      if (!steady_window()) begin
         while ($urandom_range(99) < 34) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Drop the byte stream, wait for every predicted result, then let the
   // pipeline settle.
   task automatic drain(input int unsigned settle);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (board.pending() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_sync(input logic [7:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_sync(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Send the first keep bytes of a frame under the current sync; flip
   // corrupts the check byte.
   task automatic send_frame(input logic [7:0] p [sfd_pkg::PayloadN], input logic [7:0] flip,
                             input int unsigned keep);
      logic [7:0] fb [8];
      logic [7:0] x;
      fb[0] = board.sync_value;
      x     = fb[0];
      for (int i = 0; i < sfd_pkg::PayloadN; i++) begin
         fb[i + 1] = p[i];
         x         = x ^ p[i];
      end
      fb[7] = x ^ flip;
      for (int i = 0; i < keep; i++) send_byte(fb[i]);
   endtask

   function automatic logic [7:0] pick_payload();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 8)       return 8'h00;
      else if (r < 16) return 8'hFF;
      else if (r < 21) return board.sync_value;
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] pick_status();
      case ($urandom_range(4))
         0:       return sfd_pkg::RawReverse;
         1:       return sfd_pkg::RawForward;
         2:       return sfd_pkg::RawStopped;
         3:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Mostly clean frames with random content; the rest is bad-check frames, noise
   // and truncated frames that knock the stream out of step.
   task automatic random_traffic(input int unsigned count, input bit pause_midway);
      logic [7:0]  p [sfd_pkg::PayloadN];
      logic [7:0]  b;
      int unsigned stop_at;
      int unsigned pick;
      bit          paused;
      stop_at = bytes_sent + count;
      paused  = 1'b0;
      while (bytes_sent < stop_at) begin
         if (pause_midway && !paused && bytes_sent + count / 2 >= stop_at) begin
            paused = 1'b1;
            drain(SettleTicks);
         end
         for (int i = 0; i < sfd_pkg::PayloadN; i++)
            p[i] = (i == 2 || i == 5) ? pick_status() : pick_payload();
         pick = $urandom_range(99);
         if (pick < 60) begin
            send_frame(p, 8'h00, 8);
         end else if (pick < 80) begin
            send_frame(p, ($urandom_range(3) == 0) ? 8'h00 : 8'h01 << $urandom_range(7), 8);
         end else if (pick < 90) begin
            repeat ($urandom_range(4, 1)) begin
               b = 8'($urandom);
               if (b == board.sync_value) b = b + 1'b1;
               send_byte(b);
            end
         end else begin
            send_frame(p, 8'h00, $urandom_range(7, 1));
         end
      end
   endtask

   // Extremes, all status decodes, a bad check, sync inside a frame, and a
   // sync change in the middle of a frame.
   task automatic directed_traffic();
      logic [7:0] x;
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame('{8'h00, 8'hFF, sfd_pkg::RawForward, 8'hFF, 8'h00, sfd_pkg::RawReverse},
                 8'h00, 8);
      send_frame('{sfd_pkg::SyncReset, sfd_pkg::SyncReset, sfd_pkg::RawStopped, 8'h80,
                   8'h7F, 8'h03}, 8'h01, 8);
      // start a frame, then move the sync while it is in flight
      send_frame('{8'hAA, 8'h01, sfd_pkg::RawStopped, 8'hFE, sfd_pkg::SyncReset, 8'hC3},
                 8'h00, 4);
      drain(SettleTicks);
      write_sync(8'hC3);
      x = sfd_pkg::SyncReset ^ 8'hAA ^ 8'h01 ^ sfd_pkg::RawStopped ^ 8'hFE ^
          sfd_pkg::SyncReset ^ 8'hC3;
      send_byte(8'hFE);
      send_byte(sfd_pkg::SyncReset);
      send_byte(8'hC3);
      send_byte(x);
      // the old sync value is now noise
      send_byte(sfd_pkg::SyncReset);
   endtask

   initial begin : stimulus
      logic [7:0]  sync_plan [PhaseCount];
      int unsigned per_phase;
      board      = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      sync_plan  = '{sfd_pkg::SyncReset, 8'h00, 8'hFF, 8'h00, 8'h00, sfd_pkg::SyncReset};
      sync_plan[3] = 8'($urandom);
      sync_plan[4] = 8'($urandom);
      per_phase  = ByteTarget / PhaseCount;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // first phase opens on the reset sync value with directed traffic
      directed_traffic();
      random_traffic(per_phase - bytes_sent, 1'b0);
      for (int ph = 1; ph < PhaseCount; ph++) begin
         drain(SettleTicks);
         write_sync(sync_plan[ph]);
         random_traffic(per_phase, ph == 2);
      end

      drain(SettleTicks + 4);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+design
design/sfd_pkg.sv
design/sfd_in_reg.sv
design/sfd_core.sv
design/sfd_out_reg.sv
design/sync_frame_deframer_xor_check.sv
design/sync_frame_deframer_xor_check_checker.sv
tb/testbench.sv
